### src/sosm_pkg.sv
// Shared widths, reset value and interface types of the modular sum-of-squares block.
package sosm_pkg;

    localparam int COUNT_W = 64;
    localparam int MOD_W   = 32;

    localparam logic [MOD_W-1:0] MODULUS_RESET = 32'd5;

    // Selects the operation of the shared modular step unit.
    typedef struct packed {
        logic dbl;      // Double the accumulator before the add.
    } alu_ctl_t;

    // Sequencer status as seen by the top level.
    typedef struct packed {
        logic idle;
        logic done;
    } core_status_t;

endpackage

### src/sum_of_squares_modular_unit.sv
// Top level of the modular sum-of-squares block: modulus register, core and output register.
//
// Usage: each item on the s_ channel carries a 64-bit count x; the block returns on the
// m_ channel the sum of i*i for i = 0..x modulo the modulus register, as m_residue.
// m_invalid_modulus is set, with a zero residue, when the modulus is even or a
// multiple of three. A count of all ones gives an empty sum and residue zero.
// The modulus is to be written through cfg_wr_en/cfg_wr_data only while no item is in
// flight; the block itself does not enforce this. One item is worked at a time: for a
// good item the core divides the count by three with shift-and-add steps, passes a setup
// state, runs three reductions and two modular multiplies on one shared add/compare/subtract
// unit and then moves the result into the output register. A bad modulus or an all-ones
// count goes from the setup state straight to the finish. s_ready rises in the cycle
// after the result is loaded, so no new item is taken before the last one is through.
// Stalls: a result waits in the output register while m_ready is low; the core
// holds its finished result and stays busy until that register is free.
// Reset (aresetn low, synchronous) empties the block and sets the modulus to 5.
module sum_of_squares_modular_unit import sosm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [MOD_W-1:0]   cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [COUNT_W-1:0] s_count,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [MOD_W-1:0]   m_residue,
    output logic               m_invalid_modulus
);

    logic [MOD_W-1:0] modulus_reg;
    logic             m_valid_reg, m_valid_next;
    logic [MOD_W-1:0] residue_reg;
    logic             inval_reg;

    core_status_t     core_status;
    logic [MOD_W-1:0] core_residue;
    logic             core_inval;
    logic             load;

    sosm_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .start           (s_valid && s_ready),
        .count           (s_count),
        .modulus         (modulus_reg),
        .take            (load),
        .status          (core_status),
        .residue         (core_residue),
        .invalid_modulus (core_inval)
    );

    assign s_ready = core_status.idle;
    assign load    = core_status.done && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= MODULUS_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                modulus_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            residue_reg <= core_residue;
            inval_reg   <= core_inval;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_residue         = residue_reg;
    assign m_invalid_modulus = inval_reg;

    // A flagged modulus always comes with a zero residue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_invalid_modulus |-> m_residue == '0)
        else $error("invalid modulus result carries a nonzero residue");

    // A good result is fully reduced.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_invalid_modulus |-> m_residue < modulus_reg)
        else $error("residue not reduced below the modulus");

    // The core is busy right after it takes an item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("block ready again right after accepting an item");

    // A finished result is moved out only into a free or draining output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        core_status.done && m_valid && !m_ready |=> core_status.done)
        else $error("finished result dropped while the output register was full");

endmodule

### src/sosm_mod_alu.sv
// Shared modular step unit: (acc or 2*acc) plus an addend, reduced once modulo m.
module sosm_mod_alu import sosm_pkg::*; (
    input  alu_ctl_t         ctl,
    input  logic [MOD_W-1:0] acc,
    input  logic [MOD_W-1:0] addend,
    input  logic [MOD_W-1:0] modulus,
    output logic [MOD_W-1:0] result
);

    logic [MOD_W:0] base;
    logic [MOD_W:0] sum;
    logic [MOD_W:0] diff;

    // The caller keeps the sum below twice the modulus, so one subtraction suffices.
    always_comb begin
        base   = ctl.dbl ? {acc, 1'b0} : {1'b0, acc};
        sum    = base + {1'b0, addend};
        diff   = sum - {1'b0, modulus};
        result = (sum >= {1'b0, modulus}) ? diff[MOD_W-1:0] : sum[MOD_W-1:0];
    end

endmodule

### src/sosm_core.sv
// Sequencer and operand registers that drive the shared modular step unit.
module sosm_core import sosm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [COUNT_W-1:0] count,
    input  logic [MOD_W-1:0]   modulus,
    input  logic               take,
    output core_status_t       status,
    output logic [MOD_W-1:0]   residue,
    output logic               invalid_modulus
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DIV3   = 4'd1;
    localparam logic [3:0] ST_SETUP  = 4'd2;
    localparam logic [3:0] ST_RED_A  = 4'd3;
    localparam logic [3:0] ST_RED_B  = 4'd4;
    localparam logic [3:0] ST_RED_C  = 4'd5;
    localparam logic [3:0] ST_MUL_1  = 4'd6;
    localparam logic [3:0] ST_MUL_2  = 4'd7;
    localparam logic [3:0] ST_FINISH = 4'd8;

    localparam logic [6:0] DIV_LAST = 7'd6;
    localparam logic [6:0] RED_LAST = 7'd64;
    localparam logic [6:0] MUL_LAST = 7'd63;

    // Inverse of three modulo 2^64 and the bounds that tell the remainder apart.
    localparam logic [COUNT_W-1:0] THIRD_MAX     = 64'h5555_5555_5555_5555;
    localparam logic [COUNT_W-1:0] INV3          = 64'hAAAA_AAAA_AAAA_AAAB;
    localparam logic [COUNT_W-1:0] NEG_INV3      = 64'h5555_5555_5555_5555;
    localparam logic [COUNT_W-1:0] NEG_TWO_INV3  = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [MOD_W-1:0]   MOD_THIRD_MAX = 32'h5555_5555;

    logic [3:0]         state_reg, state_next;
    logic [6:0]         cnt_reg, cnt_next;
    logic               inval_reg, inval_next;
    logic               nzero_reg, nzero_next;

    logic [COUNT_W:0]   sh_reg, sh_next;
    logic [COUNT_W-1:0] n_reg, n_next;
    logic [COUNT_W-1:0] q_reg, q_next;
    logic [MOD_W-1:0]   mt_reg, mt_next;
    logic [1:0]         r3_reg, r3_next;
    logic [1:0]         rm3_reg, rm3_next;
    logic [COUNT_W-1:0] fb_reg, fb_next;
    logic [COUNT_W:0]   c_reg, c_next;
    logic [MOD_W-1:0]   acc_reg, acc_next;
    logic [MOD_W-1:0]   fa_mod_reg, fa_mod_next;
    logic [MOD_W-1:0]   fb_mod_reg, fb_mod_next;
    logic [MOD_W-1:0]   c_mod_reg, c_mod_next;
    logic [MOD_W-1:0]   mul_a_reg, mul_a_next;

    alu_ctl_t           alu_ctl;
    logic [MOD_W-1:0]   alu_addend;
    logic [MOD_W-1:0]   alu_result;

    logic [COUNT_W-1:0] div_a;
    logic [COUNT_W-1:0] div_b;
    logic [COUNT_W-1:0] div_sum;
    logic [MOD_W-1:0]   mt_a;
    logic [MOD_W-1:0]   mt_b;
    logic [MOD_W-1:0]   mt_sum;
    logic               t_low;
    logic               t_high;
    logic [COUNT_W-1:0] n_minus1;
    logic [COUNT_W:0]   two_n_m1;
    logic [COUNT_W-1:0] fa_pre;
    logic [COUNT_W-1:0] fb_pre;
    logic [COUNT_W:0]   c_pre;
    logic [COUNT_W-1:0] fa_half;
    logic [COUNT_W-1:0] fb_half;
    logic               bad_mod;

    sosm_mod_alu u_alu (
        .ctl     (alu_ctl),
        .acc     (acc_reg),
        .addend  (alu_addend),
        .modulus (modulus),
        .result  (alu_result)
    );

    // Operand selection for the shared unit.
    always_comb begin
        alu_ctl.dbl = 1'b0;
        alu_addend  = '0;
        case (state_reg)
            ST_RED_A, ST_RED_B, ST_RED_C: begin
                alu_ctl.dbl = 1'b1;
                alu_addend  = {{(MOD_W-1){1'b0}}, sh_reg[COUNT_W]};
            end
            ST_MUL_1, ST_MUL_2: begin
                // Even steps double, odd steps add the multiplicand for a set bit.
                alu_ctl.dbl = ~cnt_reg[0];
                alu_addend  = (cnt_reg[0] && sh_reg[COUNT_W]) ? mul_a_reg : '0;
            end
            default: begin
                alu_ctl.dbl = 1'b0;
                alu_addend  = '0;
            end
        endcase
    end

    // Factor preparation: n*(n-1)*(2n-1)/6 with the three and the two removed exactly.
    always_comb begin
        n_minus1 = n_reg - 64'd1;
        two_n_m1 = {n_reg, 1'b0} - 65'd1;
        case (r3_reg)
            2'd0: begin
                fa_pre = n_minus1;
                fb_pre = q_reg;
                c_pre  = two_n_m1;
            end
            2'd1: begin
                fa_pre = q_reg;
                fb_pre = n_reg;
                c_pre  = two_n_m1;
            end
            default: begin
                fa_pre = n_minus1;
                fb_pre = n_reg;
                c_pre  = {q_reg, 1'b1};
            end
        endcase
        fa_half = fb_pre[0] ? {1'b0, fa_pre[COUNT_W-1:1]} : fa_pre;
        fb_half = fb_pre[0] ? fb_pre : {1'b0, fb_pre[COUNT_W-1:1]};
        bad_mod = !modulus[0] || (rm3_reg == 2'd0);
    end

    // Division by three as a product with the inverse of three: five shift-and-add
    // steps build x*0x55..55, the next step forms x*0xAA..AB, and the last one reads
    // the remainder off that product's range and subtracts it out, one add per cycle.
    always_comb begin
        div_a  = q_reg;
        div_b  = '0;
        mt_a   = mt_reg;
        mt_b   = '0;
        t_low  = (q_reg <= THIRD_MAX);
        t_high = (q_reg >= INV3);
        case (cnt_reg[2:0])
            3'd0: begin
                div_b = {q_reg[COUNT_W-3:0], 2'b0};
                mt_b  = {mt_reg[MOD_W-3:0], 2'b0};
            end
            3'd1: begin
                div_b = {q_reg[COUNT_W-5:0], 4'b0};
                mt_b  = {mt_reg[MOD_W-5:0], 4'b0};
            end
            3'd2: begin
                div_b = {q_reg[COUNT_W-9:0], 8'b0};
                mt_b  = {mt_reg[MOD_W-9:0], 8'b0};
            end
            3'd3: begin
                div_b = {q_reg[COUNT_W-17:0], 16'b0};
                mt_b  = {mt_reg[MOD_W-17:0], 16'b0};
            end
            3'd4: begin
                // The 32-bit modulus product is already complete here.
                div_b = {q_reg[COUNT_W-33:0], 32'b0};
            end
            3'd5: begin
                div_a = n_reg;
                div_b = {q_reg[COUNT_W-2:0], 1'b0};
                mt_a  = modulus;
                mt_b  = {mt_reg[MOD_W-2:0], 1'b0};
            end
            default: begin
                div_b = t_low ? '0 : (t_high ? NEG_INV3 : NEG_TWO_INV3);
            end
        endcase
        div_sum = div_a + div_b;
        mt_sum  = mt_a + mt_b;
    end

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        inval_next  = inval_reg;
        nzero_next  = nzero_reg;
        sh_next     = sh_reg;
        n_next      = n_reg;
        q_next      = q_reg;
        mt_next     = mt_reg;
        r3_next     = r3_reg;
        rm3_next    = rm3_reg;
        fb_next     = fb_reg;
        c_next      = c_reg;
        acc_next    = acc_reg;
        fa_mod_next = fa_mod_reg;
        fb_mod_next = fb_mod_reg;
        c_mod_next  = c_mod_reg;
        mul_a_next  = mul_a_reg;

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    n_next     = count + 64'd1;
                    nzero_next = &count;
                    q_next     = count + 64'd1;
                    mt_next    = modulus;
                    cnt_next   = '0;
                    acc_next   = '0;
                    r3_next    = '0;
                    rm3_next   = '0;
                    inval_next = 1'b0;
                    state_next = ST_DIV3;
                end
            end
            ST_DIV3: begin
                q_next  = div_sum;
                mt_next = mt_sum;
                if (cnt_reg == DIV_LAST) begin
                    r3_next    = t_low ? 2'd0 : (t_high ? 2'd1 : 2'd2);
                    // Only whether the modulus is a multiple of three matters.
                    rm3_next   = (mt_reg <= MOD_THIRD_MAX) ? 2'd0 : 2'd1;
                    state_next = ST_SETUP;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_SETUP: begin
                cnt_next = '0;
                fb_next  = fb_half;
                c_next   = c_pre;
                sh_next  = {1'b0, fa_half};
                if (bad_mod || nzero_reg) begin
                    // Residue stays at zero for a bad modulus or an empty sum.
                    inval_next = bad_mod;
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_RED_A;
                end
            end
            ST_RED_A, ST_RED_B, ST_RED_C: begin
                acc_next = alu_result;
                sh_next  = {sh_reg[COUNT_W-1:0], 1'b0};
                if (cnt_reg == RED_LAST) begin
                    cnt_next = '0;
                    acc_next = '0;
                    if (state_reg == ST_RED_A) begin
                        fa_mod_next = alu_result;
                        sh_next     = {1'b0, fb_reg};
                        state_next  = ST_RED_B;
                    end else if (state_reg == ST_RED_B) begin
                        fb_mod_next = alu_result;
                        sh_next     = c_reg;
                        state_next  = ST_RED_C;
                    end else begin
                        c_mod_next = alu_result;
                        mul_a_next = fa_mod_reg;
                        sh_next    = {fb_mod_reg, {(COUNT_W-MOD_W+1){1'b0}}};
                        state_next = ST_MUL_1;
                    end
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_MUL_1, ST_MUL_2: begin
                acc_next = alu_result;
                if (cnt_reg[0]) begin
                    sh_next = {sh_reg[COUNT_W-1:0], 1'b0};
                end
                if (cnt_reg == MUL_LAST) begin
                    cnt_next = '0;
                    if (state_reg == ST_MUL_1) begin
                        acc_next   = '0;
                        mul_a_next = c_mod_reg;
                        sh_next    = {alu_result, {(COUNT_W-MOD_W+1){1'b0}}};
                        state_next = ST_MUL_2;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_FINISH: begin
                if (take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            inval_reg <= 1'b0;
            nzero_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            inval_reg <= inval_next;
            nzero_reg <= nzero_next;
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg     <= sh_next;
        n_reg      <= n_next;
        q_reg      <= q_next;
        mt_reg     <= mt_next;
        r3_reg     <= r3_next;
        rm3_reg    <= rm3_next;
        fb_reg     <= fb_next;
        c_reg      <= c_next;
        acc_reg    <= acc_next;
        fa_mod_reg <= fa_mod_next;
        fb_mod_reg <= fb_mod_next;
        c_mod_reg  <= c_mod_next;
        mul_a_reg  <= mul_a_next;
    end

    assign status.idle     = (state_reg == ST_IDLE);
    assign status.done     = (state_reg == ST_FINISH);
    assign residue         = acc_reg;
    assign invalid_modulus = inval_reg;

endmodule
